>>> hw/rtl/qgcf_pkg.sv
// Shared types and constants for the quadratic generator cycle finder.
// Used by qgcf_arith and quadratic_generator_cycle_finder; no dependencies.
package qgcf_pkg;

    // Hash table geometry
    localparam int TABLE_ADDR_W = 16;
    localparam int TABLE_DEPTH  = 1 << TABLE_ADDR_W;
    localparam int COUNT_W      = TABLE_ADDR_W + 1;

    // Field widths
    localparam int DATA_W   = 64;
    localparam int HALF_W   = DATA_W / 2;
    localparam int STEP_W   = 16;
    localparam int REPEAT_W = 17;
    localparam int CFG_AW   = 2;

    // 0.32 fixed-point golden ratio for Fibonacci hashing
    localparam logic [HALF_W-1:0] FIB_MULT = 32'h9E37_79B9;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_MODULUS       = 2'd0,
        CFG_COEF_SQUARE   = 2'd1,
        CFG_COEF_LINEAR   = 2'd2,
        CFG_COEF_CONSTANT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] coef_square;
        logic [DATA_W-1:0] coef_linear;
        logic [DATA_W-1:0] coef_constant;
    } cfg_t;

    // Response of the arithmetic unit
    typedef struct packed {
        logic                    done;
        logic [DATA_W-1:0]       next_state;
        logic [TABLE_ADDR_W-1:0] index;
    } arith_rsp_t;

endpackage

>>> hw/rtl/quadratic_generator_cycle_finder.sv
// Top level of the quadratic generator cycle finder: stream ports, hash table
// memory and probe sequencer. Depends on qgcf_pkg and qgcf_arith.
//
// Usage:
//   Write modulus, coef_square, coef_linear and coef_constant through the
//   cfg_we/cfg_addr/cfg_wdata port while the block is idle. Send a seed as one
//   s_axis transaction; one result leaves on m_axis: first_seen_step and
//   repeat_step in m_tdata, table_full in m_tuser.
// Operation:
//   Each item first clears the 65536-entry table, one entry a cycle. Each
//   generator step then runs in the shared arithmetic unit (start, hash
//   multiply, hash accumulate, nine multiply/accumulate pairs, a sum step,
//   a bit-serial restoring modulo over all 64 dividend bits and a done step;
//   modulus zero skips the modulo), followed by a read and a check state for
//   each probe of the table memory. An item walks at most 65537 steps.
//   Only one item is in flight; s_tready is high only when idle.
// Reset:
//   Configuration returns to modulus 1 and zero coefficients; the sequencer
//   goes idle. Table contents are not reset; each item clears them.
// Stalls:
//   A result waits in the output register until taken; the block accepts the
//   next seed meanwhile and holds a later result until the register frees.
module quadratic_generator_cycle_finder (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    // Seed stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] seed
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] first_seen_step, [32:16] repeat_step, zero fill
    output logic [0:0]  m_tuser    // [0] table_full
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_CALC, ST_READ, ST_CHECK, ST_FINISH
    } state_t;

    localparam int DW  = qgcf_pkg::DATA_W;
    localparam int AW  = qgcf_pkg::TABLE_ADDR_W;
    localparam int CW  = qgcf_pkg::COUNT_W;
    localparam int SW  = qgcf_pkg::STEP_W;
    localparam int RW  = qgcf_pkg::REPEAT_W;
    localparam int DEPTH = qgcf_pkg::TABLE_DEPTH;

    state_t              state_reg, state_next;
    qgcf_pkg::cfg_t      cfg_reg, cfg_next;
    logic [DW-1:0]       s_reg, s_next;
    logic [DW-1:0]       next_s_reg, next_s_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [CW-1:0]       probe_reg, probe_next;
    logic [CW-1:0]       step_count_reg, step_count_next;
    logic                start_reg, start_next;
    logic [SW-1:0]       res_first_reg, res_first_next;
    logic [RW-1:0]       res_repeat_reg, res_repeat_next;
    logic                res_full_reg, res_full_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SW-1:0]       out_first_reg, out_first_next;
    logic [RW-1:0]       out_repeat_reg, out_repeat_next;
    logic                out_full_reg, out_full_next;

    qgcf_pkg::arith_rsp_t arith_rsp;

    // Table memory
    logic                used_mem  [DEPTH];
    logic [DW-1:0]       value_mem [DEPTH];
    logic [SW-1:0]       step_mem  [DEPTH];
    logic                rd_used_reg;
    logic [DW-1:0]       rd_value_reg;
    logic [SW-1:0]       rd_step_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_wused;

    logic [CW-1:0]       probe_inc;

    qgcf_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .state_in (s_reg),
        .cfg      (cfg_reg),
        .rsp      (arith_rsp)
    );

    assign probe_inc = probe_reg + 1'b1;

    // Sequence clearing, stepping and probing
    always_comb
    begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        s_next          = s_reg;
        next_s_next     = next_s_reg;
        idx_next        = idx_reg;
        clr_addr_next   = clr_addr_reg;
        probe_next      = probe_reg;
        step_count_next = step_count_reg;
        start_next      = 1'b0;
        res_first_next  = res_first_reg;
        res_repeat_next = res_repeat_reg;
        res_full_next   = res_full_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_first_next  = out_first_reg;
        out_repeat_next = out_repeat_reg;
        out_full_next   = out_full_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wused       = 1'b1;

        if (cfg_we)
        begin
            unique case (qgcf_pkg::cfg_idx_t'(cfg_addr))
                qgcf_pkg::CFG_MODULUS:       cfg_next.modulus       = cfg_wdata;
                qgcf_pkg::CFG_COEF_SQUARE:   cfg_next.coef_square   = cfg_wdata;
                qgcf_pkg::CFG_COEF_LINEAR:   cfg_next.coef_linear   = cfg_wdata;
                qgcf_pkg::CFG_COEF_CONSTANT: cfg_next.coef_constant = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end

        // Drop the result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    s_next        = s_tdata;
                    clr_addr_next = '0;
                    state_next    = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wused     = 1'b0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    step_count_next = '0;
                    start_next      = 1'b1;
                    state_next      = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (arith_rsp.done)
                begin
                    idx_next    = arith_rsp.index;
                    next_s_next = arith_rsp.next_state;
                    probe_next  = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!rd_used_reg)
                begin
                    mem_we          = 1'b1;
                    step_count_next = step_count_reg + 1'b1;
                    s_next          = next_s_reg;
                    start_next      = 1'b1;
                    state_next      = ST_CALC;
                end
                else if (rd_value_reg == s_reg)
                begin
                    res_first_next  = rd_step_reg;
                    res_repeat_next = RW'(step_count_reg);
                    res_full_next   = 1'b0;
                    state_next      = ST_FINISH;
                end
                else if (probe_inc == CW'(DEPTH))
                begin
                    res_first_next  = '0;
                    res_repeat_next = '0;
                    res_full_next   = 1'b1;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    probe_next = probe_inc;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_first_next  = res_first_reg;
                    out_repeat_next = res_repeat_reg;
                    out_full_next   = res_full_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= ST_IDLE;
            cfg_reg.modulus         <= 64'd1;
            cfg_reg.coef_square     <= '0;
            cfg_reg.coef_linear     <= '0;
            cfg_reg.coef_constant   <= '0;
            clr_addr_reg            <= '0;
            probe_reg               <= '0;
            step_count_reg          <= '0;
            start_reg               <= 1'b0;
            m_tvalid_reg            <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            clr_addr_reg   <= clr_addr_next;
            probe_reg      <= probe_next;
            step_count_reg <= step_count_next;
            start_reg      <= start_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        next_s_reg     <= next_s_next;
        idx_reg        <= idx_next;
        res_first_reg  <= res_first_next;
        res_repeat_reg <= res_repeat_next;
        res_full_reg   <= res_full_next;
        out_first_reg  <= out_first_next;
        out_repeat_reg <= out_repeat_next;
        out_full_reg   <= out_full_next;
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            used_mem[mem_waddr]  <= mem_wused;
            value_mem[mem_waddr] <= s_reg;
            step_mem[mem_waddr]  <= SW'(step_count_reg);
        end
        if (state_reg == ST_READ)
        begin
            rd_used_reg  <= used_mem[idx_reg];
            rd_value_reg <= value_mem[idx_reg];
            rd_step_reg  <= step_mem[idx_reg];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_repeat_reg, out_first_reg};
    assign m_tuser  = out_full_reg;

    // Stored state count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_count_reg <= CW'(DEPTH))
        else $error("step count beyond table depth");

    // Probe walk stays inside the table
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        probe_reg < CW'(DEPTH))
        else $error("probe count beyond table depth");

    // Arithmetic results arrive only while the sequencer waits for them
    a_arith_sync: assert property (@(posedge clk) disable iff (!rst_n)
        arith_rsp.done |-> (state_reg == ST_CALC))
        else $error("arithmetic result outside wait state");

    // A full table reports zero step fields
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("full flag with nonzero step fields");

    // A new store launches the next generator step
    a_store_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !rd_used_reg) |=> (start_reg && state_reg == ST_CALC))
        else $error("store did not launch next step");

endmodule

>>> hw/rtl/qgcf_arith.sv
// Iterative arithmetic unit: hash of the current state and next generator state.
// One shared 32x32 multiplier and a bit-serial restoring modulo; uses qgcf_pkg.
module qgcf_arith (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qgcf_pkg::DATA_W-1:0]   state_in,
    input  qgcf_pkg::cfg_t                cfg,
    output qgcf_pkg::arith_rsp_t          rsp
);

    typedef enum logic [2:0] {
        A_IDLE, A_HASH_MUL, A_HASH_ACC, A_MUL, A_ACC, A_SUM, A_DIV, A_DONE
    } a_state_t;

    typedef enum logic [1:0] { OP_SS, OP_TA, OP_SB } op_t;

    localparam int DW = qgcf_pkg::DATA_W;
    localparam int HW = qgcf_pkg::HALF_W;
    localparam int AW = qgcf_pkg::TABLE_ADDR_W;
    localparam int CNT_W = $clog2(DW);

    a_state_t          state_reg, state_next;
    op_t               op_reg, op_next;
    logic [1:0]        pp_reg, pp_next;
    logic [DW-1:0]     s_reg, s_next;
    logic [DW-1:0]     x_reg, x_next;
    logic [DW-1:0]     y_reg, y_next;
    logic [DW-1:0]     acc_reg, acc_next;
    logic [DW-1:0]     prod_reg, prod_next;
    logic [DW-1:0]     t_reg, t_next;
    logic [DW-1:0]     u_reg, u_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     dvd_reg, dvd_next;
    logic [DW-1:0]     res_reg, res_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]     idx_reg, idx_next;

    logic [HW-1:0]     mul_a, mul_b;
    logic [DW-1:0]     product;
    logic [DW-1:0]     acc_sum;
    logic [DW-1:0]     sum_v;
    logic [DW:0]       div_r;
    logic [DW:0]       div_d;
    logic [DW-1:0]     rem_step;

    // Select partial-product operands for the shared multiplier
    always_comb
    begin
        mul_a = x_reg[HW-1:0];
        mul_b = y_reg[HW-1:0];
        if (state_reg == A_HASH_MUL)
        begin
            mul_a = s_reg[HW-1:0];
            mul_b = qgcf_pkg::FIB_MULT;
        end
        else if (pp_reg == 2'd1)
        begin
            mul_b = y_reg[DW-1:HW];
        end
        else if (pp_reg == 2'd2)
        begin
            mul_a = x_reg[DW-1:HW];
        end
    end

    assign product = mul_a * mul_b;

    // Accumulate the wrapped 64-bit product
    assign acc_sum = (pp_reg == 2'd0) ? acc_reg + prod_reg
                                      : acc_reg + {prod_reg[HW-1:0], {HW{1'b0}}};

    assign sum_v = t_reg + u_reg + cfg.coef_constant;

    // One restoring-division step on the remainder
    assign div_r    = {rem_reg, dvd_reg[DW-1]};
    assign div_d    = {1'b0, cfg.modulus};
    assign rem_step = (div_r >= div_d) ? DW'(div_r - div_d) : div_r[DW-1:0];

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        pp_next    = pp_reg;
        s_next     = s_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        t_next     = t_reg;
        u_next     = u_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    s_next     = state_in;
                    state_next = A_HASH_MUL;
                end
            end
            A_HASH_MUL:
            begin
                prod_next  = product;
                state_next = A_HASH_ACC;
            end
            A_HASH_ACC:
            begin
                idx_next   = prod_reg[AW-1:0];
                x_next     = s_reg;
                y_next     = s_reg;
                op_next    = OP_SS;
                pp_next    = 2'd0;
                acc_next   = '0;
                state_next = A_MUL;
            end
            A_MUL:
            begin
                prod_next  = product;
                state_next = A_ACC;
            end
            A_ACC:
            begin
                if (pp_reg != 2'd2)
                begin
                    acc_next   = acc_sum;
                    pp_next    = pp_reg + 2'd1;
                    state_next = A_MUL;
                end
                else
                begin
                    acc_next = '0;
                    pp_next  = 2'd0;
                    unique case (op_reg)
                        OP_SS:
                        begin
                            x_next     = acc_sum;
                            y_next     = cfg.coef_square;
                            op_next    = OP_TA;
                            state_next = A_MUL;
                        end
                        OP_TA:
                        begin
                            t_next     = acc_sum;
                            x_next     = s_reg;
                            y_next     = cfg.coef_linear;
                            op_next    = OP_SB;
                            state_next = A_MUL;
                        end
                        OP_SB:
                        begin
                            u_next     = acc_sum;
                            state_next = A_SUM;
                        end
                        default:
                        begin
                            state_next = A_IDLE;
                        end
                    endcase
                end
            end
            A_SUM:
            begin
                if (cfg.modulus == '0)
                begin
                    res_next   = sum_v;
                    state_next = A_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    dvd_next   = sum_v;
                    cnt_next   = '0;
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    res_next   = rem_step;
                    state_next = A_DONE;
                end
            end
            A_DONE:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    // Hold sequencer state, operation and step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            op_reg    <= OP_SS;
            pp_reg    <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            pp_reg    <= pp_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        res_reg  <= res_next;
        idx_reg  <= idx_next;
    end

    assign rsp.done       = (state_reg == A_DONE);
    assign rsp.next_state = res_reg;
    assign rsp.index      = idx_reg;

endmodule
